// File: rtl/fcc_pkg.sv
// Shared types, constants and calendar helpers for the fast clock calendar tick unit.
package fcc_pkg;

  // Input action codes
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_LOAD = 1'b1;

  // Configuration register indexes (paddr[3:2])
  localparam int unsigned REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_RATE    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_RUNNING = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_ENABLE  = 2'd2;

  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  // Field widths
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned YEAR_W   = 12;
  localparam int unsigned RATE_W   = 12;
  localparam int unsigned ACC_W    = 19;

  // Time scaling: one tick adds TICK_SCALE * |rate|, a minute costs MINUTE_THRESHOLD
  localparam logic [ACC_W:0] MINUTE_THRESHOLD = 20'd240000;
  localparam logic [6:0]     TICK_SCALE       = 7'd100;

  typedef logic [HOUR_W-1:0]   hour_t;
  typedef logic [MINUTE_W-1:0] minute_t;
  typedef logic [DAY_W-1:0]    day_t;
  typedef logic [MONTH_W-1:0]  month_t;
  typedef logic [YEAR_W-1:0]   year_t;

  typedef struct packed {
    hour_t   hour_now;
    minute_t minute_now;
    day_t    day_now;
    month_t  month_now;
    year_t   year_now;
    logic    minute_stepped;
    logic    day_rolled;
    logic    month_changed;
    logic    year_changed;
  } result_t;

  // Days in a month; anything outside 1..12 counts as 30.
  function automatic day_t month_days(input month_t m, input logic leap);
    day_t d;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
      4'd2:                                       d = leap ? 5'd29 : 5'd28;
      default:                                    d = 5'd30;
    endcase
    return d;
  endfunction

endpackage

// File: rtl/fcc_if.sv
// Valid/ready channel interfaces for tick/load words and result words.
interface fcc_in_if;
  logic             valid;
  logic             ready;
  logic             action;
  fcc_pkg::hour_t   load_hour;
  fcc_pkg::minute_t load_minute;
  fcc_pkg::month_t  load_month;
  fcc_pkg::day_t    load_day;
  fcc_pkg::year_t   load_year;

  modport source (output valid, action, load_hour, load_minute, load_month, load_day,
                  load_year, input ready);
  modport sink   (input valid, action, load_hour, load_minute, load_month, load_day,
                  load_year, output ready);
endinterface

interface fcc_out_if;
  logic             valid;
  logic             ready;
  fcc_pkg::hour_t   hour_now;
  fcc_pkg::minute_t minute_now;
  fcc_pkg::day_t    day_now;
  fcc_pkg::month_t  month_now;
  fcc_pkg::year_t   year_now;
  logic             minute_stepped;
  logic             day_rolled;
  logic             month_changed;
  logic             year_changed;

  modport source (output valid, hour_now, minute_now, day_now, month_now, year_now,
                  minute_stepped, day_rolled, month_changed, year_changed, input ready);
  modport sink   (input valid, hour_now, minute_now, day_now, month_now, year_now,
                  minute_stepped, day_rolled, month_changed, year_changed, output ready);
endinterface

// File: rtl/fast_clock_calendar_tick_unit.sv
// Fast clock calendar tick unit: one rate-scaled model-railway clock with date carry.
//
// One word in, one result word out, one word per clock cycle while out.ready is
// high. A tick word (action 0) stands for 100 ms: when enabled, running and
// rate != 0 it adds 100*|rate| to a 19-bit accumulator, and when that reaches
// 240000 the clock moves one minute, forward for a positive rate and backward for a
// negative one, carrying through hour, day (Gregorian leap years), month and the
// 12-bit year. A load word (action 1) sets time and date as given and keeps the
// accumulator. The whole update is one pass of logic from the clock state registers
// to the result register. A two-entry output buffer (result register plus skid
// register) keeps in.ready high for one extra word while out.ready is low; in.ready
// drops only when both entries are full. Configuration (APB, 4-bit byte address):
// 0x0 rate (12-bit signed, 2 fraction bits, 4 = real time), 0x4 running, 0x8
// consumer_enabled. pready is tied high; writes land on the access cycle. The user
// ensures registers are written only while the block is idle; it is not enforced.
module fast_clock_calendar_tick_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  fcc_in_if.sink                        in_ch,
  fcc_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fcc_pkg::PADDR_W-1:0]   paddr,
  input  logic [fcc_pkg::PDATA_W-1:0]   pwdata,
  output logic [fcc_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [fcc_pkg::RATE_W-1:0] rate_r;
  logic                       running_r;
  logic                       enable_r;
  logic                       cfg_wr;
  logic [fcc_pkg::REG_IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[fcc_pkg::REG_IDX_W+1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r    <= '0;
      running_r <= 1'b0;
      enable_r  <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        fcc_pkg::REG_RATE:    rate_r    <= pwdata[fcc_pkg::RATE_W-1:0];
        fcc_pkg::REG_RUNNING: running_r <= pwdata[0];
        fcc_pkg::REG_ENABLE:  enable_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      fcc_pkg::REG_RATE:    prdata = {{(fcc_pkg::PDATA_W-fcc_pkg::RATE_W){1'b0}}, rate_r};
      fcc_pkg::REG_RUNNING: prdata = {{(fcc_pkg::PDATA_W-1){1'b0}}, running_r};
      fcc_pkg::REG_ENABLE:  prdata = {{(fcc_pkg::PDATA_W-1){1'b0}}, enable_r};
      default:              prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Clock state
  // ---------------------------------------------------------------------------
  fcc_pkg::minute_t           minute_r, minute_nxt;
  fcc_pkg::hour_t             hour_r, hour_nxt;
  fcc_pkg::day_t              day_r, day_nxt;
  fcc_pkg::month_t            month_r, month_nxt;
  fcc_pkg::year_t             year_r, year_nxt;
  logic [fcc_pkg::ACC_W-1:0]  acc_r, acc_nxt;

  logic in_acc;

  // ---------------------------------------------------------------------------
  // Accumulator: |rate| (0x800 reads as 2048), times 100, compare against 240000.
  // acc stays below 240000, so acc + 204800 still fits in 19 bits.
  // ---------------------------------------------------------------------------
  logic                       rate_neg;
  logic [fcc_pkg::RATE_W-1:0] rate_mag;
  logic [fcc_pkg::ACC_W-1:0]  acc_inc;
  logic [fcc_pkg::ACC_W:0]    acc_sum;
  logic                       tick_live;
  logic                       step;

  assign rate_neg  = rate_r[fcc_pkg::RATE_W-1];
  assign rate_mag  = rate_neg ? (~rate_r + 12'd1) : rate_r;
  assign acc_inc   = {7'd0, rate_mag} * fcc_pkg::TICK_SCALE;
  assign acc_sum   = {1'b0, acc_r} + {1'b0, acc_inc};
  assign tick_live = (in_ch.action == fcc_pkg::ACT_TICK) && enable_r && running_r &&
                     (rate_r != '0);
  assign step      = tick_live && (acc_sum >= fcc_pkg::MINUTE_THRESHOLD);

  always_comb begin
    acc_nxt = acc_r;
    if (tick_live) begin
      acc_nxt = step ? fcc_pkg::ACC_W'(acc_sum - fcc_pkg::MINUTE_THRESHOLD)
                     : acc_sum[fcc_pkg::ACC_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Leap year of the current year. Quotient by 100 via reciprocal (exact for
  // 12-bit years); divisible by 400 when divisible by 100 with quotient % 4 == 0.
  // ---------------------------------------------------------------------------
  logic [24:0] yq_prod;
  logic [5:0]  y_q100;
  logic [12:0] y_back;
  logic        leap;

  assign yq_prod = {13'd0, year_r} * 25'd5243;
  assign y_q100  = yq_prod[24:19];
  assign y_back  = {1'b0, y_q100, 6'd0} + {2'b0, y_q100, 5'd0} + {5'b0, y_q100, 2'd0};
  assign leap    = (year_r[1:0] == 2'd0) &&
                   ((y_back != {1'b0, year_r}) || (y_q100[1:0] == 2'd0));

  // Month lengths seen by a forward carry (current month) and a backward borrow
  // (previous month; borrow from January wraps to December = 31 separately).
  fcc_pkg::day_t mdays_cur;
  fcc_pkg::day_t mdays_prev;
  fcc_pkg::month_t month_dec;

  assign month_dec  = month_r - 4'd1;
  assign mdays_cur  = fcc_pkg::month_days(month_r, leap);
  assign mdays_prev = fcc_pkg::month_days(month_dec, leap);

  // ---------------------------------------------------------------------------
  // Calendar carry / borrow
  // ---------------------------------------------------------------------------
  logic [6:0] min_inc;
  logic [5:0] hour_inc;
  logic [5:0] day_inc;
  logic [4:0] month_inc;
  logic       rolled, mon_chg, yr_chg;

  assign min_inc   = {1'b0, minute_r} + 7'd1;
  assign hour_inc  = {1'b0, hour_r} + 6'd1;
  assign day_inc   = {1'b0, day_r} + 6'd1;
  assign month_inc = {1'b0, month_r} + 5'd1;

  always_comb begin
    minute_nxt = minute_r;
    hour_nxt   = hour_r;
    day_nxt    = day_r;
    month_nxt  = month_r;
    year_nxt   = year_r;
    rolled     = 1'b0;
    mon_chg    = 1'b0;
    yr_chg     = 1'b0;
    if (in_ch.action == fcc_pkg::ACT_LOAD) begin
      minute_nxt = in_ch.load_minute;
      hour_nxt   = in_ch.load_hour;
      day_nxt    = in_ch.load_day;
      month_nxt  = in_ch.load_month;
      year_nxt   = in_ch.load_year;
    end else if (step && !rate_neg) begin
      if (min_inc >= 7'd60) begin
        minute_nxt = '0;
        if (hour_inc >= 6'd24) begin
          hour_nxt = '0;
          rolled   = 1'b1;
          if (day_inc > {1'b0, mdays_cur}) begin
            day_nxt = 5'd1;
            mon_chg = 1'b1;
            if (month_inc > 5'd12) begin
              month_nxt = 4'd1;
              year_nxt  = year_r + 12'd1;
              yr_chg    = 1'b1;
            end else begin
              month_nxt = month_inc[3:0];
            end
          end else begin
            day_nxt = day_inc[4:0];
          end
        end else begin
          hour_nxt = hour_inc[4:0];
        end
      end else begin
        minute_nxt = min_inc[5:0];
      end
    end else if (step) begin
      if (minute_r != '0) begin
        minute_nxt = minute_r - 6'd1;
      end else begin
        minute_nxt = 6'd59;
        if (hour_r != '0) begin
          hour_nxt = hour_r - 5'd1;
        end else begin
          hour_nxt = 5'd23;
          rolled   = 1'b1;
          if (day_r <= 5'd1) begin
            mon_chg = 1'b1;
            if (month_r <= 4'd1) begin
              month_nxt = 4'd12;
              year_nxt  = year_r - 12'd1;
              yr_chg    = 1'b1;
              day_nxt   = 5'd31;
            end else begin
              month_nxt = month_dec;
              day_nxt   = mdays_prev;
            end
          end else begin
            day_nxt = day_r - 5'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      minute_r <= '0;
      hour_r   <= '0;
      day_r    <= '0;
      month_r  <= '0;
      year_r   <= '0;
      acc_r    <= '0;
    end else if (in_acc) begin
      minute_r <= minute_nxt;
      hour_r   <= hour_nxt;
      day_r    <= day_nxt;
      month_r  <= month_nxt;
      year_r   <= year_nxt;
      acc_r    <= acc_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result word and output buffer (result register + skid register)
  // ---------------------------------------------------------------------------
  fcc_pkg::result_t res_new;
  fcc_pkg::result_t out_r, skid_r;
  logic             out_valid_r, skid_valid_r;
  logic             out_free;

  assign res_new.hour_now       = hour_nxt;
  assign res_new.minute_now     = minute_nxt;
  assign res_new.day_now        = day_nxt;
  assign res_new.month_now      = month_nxt;
  assign res_new.year_now       = year_nxt;
  assign res_new.minute_stepped = step;
  assign res_new.day_rolled     = rolled;
  assign res_new.month_changed  = mon_chg;
  assign res_new.year_changed   = yr_chg;

  assign in_ch.ready = !skid_valid_r;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_r <= skid_valid_r || in_acc;
      end
      if (skid_valid_r) begin
        skid_valid_r <= !out_ch.ready;
      end else begin
        skid_valid_r <= in_acc && !out_free;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_valid_r ? skid_r : res_new;
    end
    if (in_acc && !out_free) begin
      skid_r <= res_new;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.hour_now       = out_r.hour_now;
  assign out_ch.minute_now     = out_r.minute_now;
  assign out_ch.day_now        = out_r.day_now;
  assign out_ch.month_now      = out_r.month_now;
  assign out_ch.year_now       = out_r.year_now;
  assign out_ch.minute_stepped = out_r.minute_stepped;
  assign out_ch.day_rolled     = out_r.day_rolled;
  assign out_ch.month_changed  = out_r.month_changed;
  assign out_ch.year_changed   = out_r.year_changed;

endmodule

// File: test/tb_top.sv
// Self-checking bench for the fast clock calendar tick unit: directed plan, then random phases.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Minute cost and per-tick gain of the rate-scaled accumulator
  localparam int unsigned MINUTE_COST = 240000;
  localparam int unsigned TICK_GAIN   = 100;
  localparam int unsigned ACC_MASK    = 32'h7FFFF;
  localparam int unsigned RANDOM_WORDS = 950;
  // Run limit for the watchdog, with a wide margin over the slowest legal run
  localparam int unsigned CYCLE_LIMIT = 200000;

  // One input word as the bench sees it
  typedef struct packed {
    logic             action;
    fcc_pkg::hour_t   hour;
    fcc_pkg::minute_t minute;
    fcc_pkg::month_t  month;
    fcc_pkg::day_t    day;
    fcc_pkg::year_t   year;
  } tick_word_t;

  // Directed plan: a row is either a register write or a word.
  // Pinned rows carry a hand-written expected result.
  typedef enum logic {ROW_CFG, ROW_WORD} row_kind_t;

  typedef struct {
    row_kind_t                      kind;
    logic [fcc_pkg::REG_IDX_W-1:0]  reg_idx;
    logic [fcc_pkg::PDATA_W-1:0]    reg_val;
    tick_word_t                     word;
    bit                             pinned;
    fcc_pkg::result_t               want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;

  // APB side
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [fcc_pkg::PADDR_W-1:0] paddr;
  logic [fcc_pkg::PDATA_W-1:0] pwdata;
  logic [fcc_pkg::PDATA_W-1:0] prdata;
  logic                        pready;

  fcc_in_if  in_if ();
  fcc_out_if out_if ();

  // Result-side ready comes from a bench variable so it is known from time 0
  logic sink_ready = 1'b0;
  assign out_if.ready = sink_ready;

  // Hand-written expectation that travels with the word on the input channel
  logic             pin_valid;
  fcc_pkg::result_t pin_res;

  // Predictor copy of the clock and its registers
  fcc_pkg::hour_t    now_hour   = '0;
  fcc_pkg::minute_t  now_minute = '0;
  fcc_pkg::day_t     now_day    = '0;
  fcc_pkg::month_t   now_month  = '0;
  fcc_pkg::year_t    now_year   = '0;
  int unsigned       tick_acc   = 0;
  logic [fcc_pkg::RATE_W-1:0] set_rate = '0;
  logic              set_running = 1'b0;
  logic              set_enabled = 1'b0;

  // Clock readings still owed by the block, oldest first
  fcc_pkg::result_t pending_times[$];

  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          calm = 1'b0;      // phase with no idling on either side
  int unsigned n_words = 0, n_loads = 0, n_steps = 0;
  int unsigned n_rolls = 0, n_months = 0, n_years = 0, n_settings = 0;

  fast_clock_calendar_tick_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Gregorian month length; months outside 1..12 count as 30 days
  function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
    bit leap;
    leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap ? 29 : 28;
      default:               return 30;
    endcase
  endfunction

  // Applies one word to the predicted clock and returns the reading it should produce
  task automatic advance_clock(input tick_word_t w, output fcc_pkg::result_t r);
    int unsigned mag, mi, h, d, m;
    logic        back;
    r = '0;
    if (w.action == fcc_pkg::ACT_LOAD) begin
      // Loads land as given, range or not; accumulator untouched
      now_hour   = w.hour;
      now_minute = w.minute;
      now_month  = w.month;
      now_day    = w.day;
      now_year   = w.year;
    end else if (set_enabled && set_running && set_rate != '0) begin
      back = set_rate[fcc_pkg::RATE_W-1];
      mag  = back ? (32'd4096 - 32'(set_rate)) : 32'(set_rate);
      tick_acc = tick_acc + TICK_GAIN * mag;
      if (tick_acc >= MINUTE_COST) begin
        tick_acc = tick_acc - MINUTE_COST;
        r.minute_stepped = 1'b1;
        if (!back) begin
          // Forward carry: anything past the top of its range restarts
          mi = now_minute + 1;
          if (mi >= 60) begin
            mi = 0;
            h  = now_hour + 1;
            if (h >= 24) begin
              h = 0;
              d = now_day + 1;
              r.day_rolled = 1'b1;
              if (d > days_in_month(now_month, now_year)) begin
                d = 1;
                m = now_month + 1;
                if (m > 12) begin
                  m = 1;
                  now_year = fcc_pkg::year_t'(now_year + 1);
                  r.year_changed = 1'b1;
                end
                now_month = fcc_pkg::month_t'(m);
                r.month_changed = 1'b1;
              end
              now_day = fcc_pkg::day_t'(d);
            end
            now_hour = fcc_pkg::hour_t'(h);
          end
          now_minute = fcc_pkg::minute_t'(mi);
        end else if (now_minute != '0) begin
          now_minute = fcc_pkg::minute_t'(now_minute - 1);
        end else begin
          // Backward borrow; day 0 or 1 and month 0 or 1 both borrow
          now_minute = fcc_pkg::minute_t'(59);
          if (now_hour != '0) begin
            now_hour = fcc_pkg::hour_t'(now_hour - 1);
          end else begin
            now_hour = fcc_pkg::hour_t'(23);
            r.day_rolled = 1'b1;
            if (now_day <= 1) begin
              if (now_month <= 1) begin
                now_month = fcc_pkg::month_t'(12);
                now_year  = fcc_pkg::year_t'(now_year - 1);
                r.year_changed = 1'b1;
              end else begin
                now_month = fcc_pkg::month_t'(now_month - 1);
              end
              now_day = fcc_pkg::day_t'(days_in_month(now_month, now_year));
              r.month_changed = 1'b1;
            end else begin
              now_day = fcc_pkg::day_t'(now_day - 1);
            end
          end
        end
      end
      tick_acc = tick_acc & ACC_MASK;
    end
    r.hour_now   = now_hour;
    r.minute_now = now_minute;
    r.day_now    = now_day;
    r.month_now  = now_month;
    r.year_now   = now_year;
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] ERROR %s", $time, msg);
  endtask

  task automatic compare_time(input fcc_pkg::result_t want, input fcc_pkg::result_t seen);
    if (seen.hour_now !== want.hour_now)
      report_mismatch($sformatf("hour_now exp %0d got %0d", want.hour_now, seen.hour_now));
    if (seen.minute_now !== want.minute_now)
      report_mismatch($sformatf("minute_now exp %0d got %0d", want.minute_now, seen.minute_now));
    if (seen.day_now !== want.day_now)
      report_mismatch($sformatf("day_now exp %0d got %0d", want.day_now, seen.day_now));
    if (seen.month_now !== want.month_now)
      report_mismatch($sformatf("month_now exp %0d got %0d", want.month_now, seen.month_now));
    if (seen.year_now !== want.year_now)
      report_mismatch($sformatf("year_now exp %0d got %0d", want.year_now, seen.year_now));
    if (seen.minute_stepped !== want.minute_stepped)
      report_mismatch($sformatf("minute_stepped exp %0b got %0b",
                                want.minute_stepped, seen.minute_stepped));
    if (seen.day_rolled !== want.day_rolled)
      report_mismatch($sformatf("day_rolled exp %0b got %0b", want.day_rolled, seen.day_rolled));
    if (seen.month_changed !== want.month_changed)
      report_mismatch($sformatf("month_changed exp %0b got %0b",
                                want.month_changed, seen.month_changed));
    if (seen.year_changed !== want.year_changed)
      report_mismatch($sformatf("year_changed exp %0b got %0b",
                                want.year_changed, seen.year_changed));
  endtask

  // Watches both channels at every edge. Results are checked before the new
  // word is queued so a same-edge result can never match its own word.
  // Also runs the result-side stall: after each result taken, out.ready may be held low, never in the calm phase.
  always @(posedge clk) begin : watch
    tick_word_t       got;
    fcc_pkg::result_t want;
    fcc_pkg::result_t seen;
    int unsigned      stall_left;
    if (rst_n === 1'b1) begin
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        seen.hour_now       = out_if.hour_now;
        seen.minute_now     = out_if.minute_now;
        seen.day_now        = out_if.day_now;
        seen.month_now      = out_if.month_now;
        seen.year_now       = out_if.year_now;
        seen.minute_stepped = out_if.minute_stepped;
        seen.day_rolled     = out_if.day_rolled;
        seen.month_changed  = out_if.month_changed;
        seen.year_changed   = out_if.year_changed;
        if (pending_times.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          compare_time(pending_times.pop_front(), seen);
        end
        stall_left = calm ? 0 : $urandom_range(0, 3);
        if (stall_left != 0)
          sink_ready <= 1'b0;
      end else if (!sink_ready) begin
        if (stall_left > 1)
          stall_left--;
        else
          sink_ready <= 1'b1;
      end

      if (in_if.valid === 1'b1 && in_if.ready === 1'b1) begin
        got.action = in_if.action;
        got.hour   = in_if.load_hour;
        got.minute = in_if.load_minute;
        got.month  = in_if.load_month;
        got.day    = in_if.load_day;
        got.year   = in_if.load_year;
        // The predictor always runs so its state follows the block
        advance_clock(got, want);
        if (pin_valid)
          want = pin_res;
        pending_times.push_back(want);
        n_words++;
        if (got.action == fcc_pkg::ACT_LOAD) n_loads++;
        if (want.minute_stepped)             n_steps++;
        if (want.day_rolled)                 n_rolls++;
        if (want.month_changed)              n_months++;
        if (want.year_changed)               n_years++;
      end
    end else begin
      stall_left = 0;
    end
  end

  // Watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("fast_clock_calendar_tick_unit: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Tick with garbage in the load fields; the block must ignore them
  function automatic tick_word_t junk_tick();
    tick_word_t w;
    w.action = fcc_pkg::ACT_TICK;
    w.hour   = fcc_pkg::hour_t'($urandom);
    w.minute = fcc_pkg::minute_t'($urandom);
    w.month  = fcc_pkg::month_t'($urandom);
    w.day    = fcc_pkg::day_t'($urandom);
    w.year   = fcc_pkg::year_t'($urandom);
    return w;
  endfunction

  function automatic plan_row_t cfg_row(input logic [fcc_pkg::REG_IDX_W-1:0] idx,
                                        input logic [fcc_pkg::PDATA_W-1:0] val);
    plan_row_t r;
    r.kind    = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = val;
    r.word    = '0;
    r.pinned  = 1'b0;
    r.want    = '0;
    return r;
  endfunction

  function automatic plan_row_t tick_row();
    plan_row_t r;
    r = cfg_row(fcc_pkg::REG_RATE, '0);
    r.kind = ROW_WORD;
    r.word = junk_tick();
    return r;
  endfunction

  // A load reads back exactly what it wrote, flags clear
  function automatic plan_row_t load_row(input int unsigned h, input int unsigned mi,
                                         input int unsigned mo, input int unsigned d,
                                         input int unsigned y);
    plan_row_t r;
    r = tick_row();
    r.word.action = fcc_pkg::ACT_LOAD;
    r.word.hour   = fcc_pkg::hour_t'(h);
    r.word.minute = fcc_pkg::minute_t'(mi);
    r.word.month  = fcc_pkg::month_t'(mo);
    r.word.day    = fcc_pkg::day_t'(d);
    r.word.year   = fcc_pkg::year_t'(y);
    r.pinned = 1'b1;
    r.want.hour_now   = fcc_pkg::hour_t'(h);
    r.want.minute_now = fcc_pkg::minute_t'(mi);
    r.want.month_now  = fcc_pkg::month_t'(mo);
    r.want.day_now    = fcc_pkg::day_t'(d);
    r.want.year_now   = fcc_pkg::year_t'(y);
    return r;
  endfunction

  // Load aimed at calendar edges most of the time, raw bits otherwise
  function automatic tick_word_t random_load();
    tick_word_t  w;
    int unsigned y, mo, len;
    w = junk_tick();
    w.action = fcc_pkg::ACT_LOAD;
    if ($urandom_range(0, 3) == 0)
      return w;
    case ($urandom_range(0, 7))
      0:       y = 2000;
      1:       y = 1900;
      2:       y = 2024;
      3:       y = 0;
      4:       y = 4095;
      5:       y = 4 * $urandom_range(0, 1023);
      default: y = $urandom_range(0, 4095);
    endcase
    mo  = ($urandom_range(0, 4) == 0) ? 2 : $urandom_range(1, 12);
    len = days_in_month(mo, y);
    case ($urandom_range(0, 3))
      0:       w.day = fcc_pkg::day_t'(1);
      1:       w.day = fcc_pkg::day_t'(len);
      2:       w.day = fcc_pkg::day_t'(len - 1);
      default: w.day = fcc_pkg::day_t'($urandom_range(1, len));
    endcase
    case ($urandom_range(0, 3))
      0, 1:    w.hour = fcc_pkg::hour_t'(23);
      2:       w.hour = fcc_pkg::hour_t'(0);
      default: w.hour = fcc_pkg::hour_t'($urandom_range(0, 23));
    endcase
    case ($urandom_range(0, 4))
      0:       w.minute = fcc_pkg::minute_t'(59);
      1:       w.minute = fcc_pkg::minute_t'(58);
      2:       w.minute = fcc_pkg::minute_t'(0);
      3:       w.minute = fcc_pkg::minute_t'(1);
      default: w.minute = fcc_pkg::minute_t'($urandom_range(0, 59));
    endcase
    w.month = fcc_pkg::month_t'(mo);
    w.year  = fcc_pkg::year_t'(y);
    return w;
  endfunction

  // Mostly fast rates so minutes step often; extremes and slow rates mixed in
  function automatic logic [fcc_pkg::RATE_W-1:0] random_rate();
    case ($urandom_range(0, 9))
      0:       return 12'h7FF;                   // fastest forward
      1:       return 12'h800;                   // fastest backward
      2:       return 12'hFFF;                   // slowest backward
      3:       return 12'h001;
      4:       return 12'h004;                   // real time
      5:       return 12'h000;
      6, 7:    return fcc_pkg::RATE_W'($urandom_range(1200, 2047));
      8:       return fcc_pkg::RATE_W'(13'h1000 - $urandom_range(1200, 2048));
      default: return fcc_pkg::RATE_W'($urandom_range(0, 4095));
    endcase
  endfunction

  // Setup then access cycle; the register lands at the access edge
  task automatic write_reg(input logic [fcc_pkg::REG_IDX_W-1:0] idx,
                           input logic [fcc_pkg::PDATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    case (idx)
      fcc_pkg::REG_RATE:    set_rate    = val[fcc_pkg::RATE_W-1:0];
      fcc_pkg::REG_RUNNING: set_running = val[0];
      fcc_pkg::REG_ENABLE:  set_enabled = val[0];
      default:              ;
    endcase
    n_settings++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Drive one word after a random gap; returns at the edge it was taken.
  // With no gap valid simply stays high for the next word.
  task automatic send_word(input tick_word_t w, input bit pinned,
                           input fcc_pkg::result_t want);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.action      <= w.action;
    in_if.load_hour   <= w.hour;
    in_if.load_minute <= w.minute;
    in_if.load_month  <= w.month;
    in_if.load_day    <= w.day;
    in_if.load_year   <= w.year;
    pin_valid         <= pinned;
    pin_res           <= want;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
  endtask

  // Drop valid and wait for every owed result; every word yields one, so
  // an empty queue means the block is idle
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_times.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    plan_row_t   plan[$];
    plan_row_t   r;
    int unsigned random_sent;
    int unsigned len;

    rst_n             <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.action      <= fcc_pkg::ACT_TICK;
    in_if.load_hour   <= '0;
    in_if.load_minute <= '0;
    in_if.load_month  <= '0;
    in_if.load_day    <= '0;
    in_if.load_year   <= '0;
    pin_valid         <= 1'b0;
    pin_res           <= '0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;

    // Tick straight out of reset: disabled, stopped, rate 0 -> all zero
    r = tick_row();
    r.pinned = 1'b1;
    plan.push_back(r);
    plan.push_back(cfg_row(fcc_pkg::REG_ENABLE, 32'd1));
    plan.push_back(cfg_row(fcc_pkg::REG_RUNNING, 32'd1));
    plan.push_back(cfg_row(fcc_pkg::REG_RATE, 32'h7FF));
    // Every load field at its top code, then step forward out of range
    plan.push_back(load_row(31, 63, 15, 31, 4095));
    plan.push_back(tick_row());
    plan.push_back(tick_row());
    // Leap year, century non-leap, and year wrap going forward
    plan.push_back(load_row(23, 59, 2, 28, 2024));
    plan.push_back(tick_row());
    plan.push_back(load_row(23, 59, 2, 28, 1900));
    plan.push_back(tick_row());
    plan.push_back(load_row(23, 59, 12, 31, 4095));
    plan.push_back(tick_row());
    // Most negative rate: backward borrows
    plan.push_back(cfg_row(fcc_pkg::REG_RATE, 32'h800));
    plan.push_back(load_row(0, 0, 3, 1, 2000));     // back into a 400-year leap Feb
    plan.push_back(tick_row());
    plan.push_back(load_row(0, 0, 1, 1, 0));        // year wraps down to 4095
    plan.push_back(tick_row());
    plan.push_back(tick_row());
    plan.push_back(load_row(0, 0, 15, 0, 5));       // invalid month just decrements
    plan.push_back(tick_row());
    plan.push_back(load_row(0, 0, 0, 0, 100));      // month 0 borrows like month 1
    plan.push_back(tick_row());
    // Idle ticks: stopped, zero rate, disabled
    plan.push_back(cfg_row(fcc_pkg::REG_RUNNING, 32'd0));
    plan.push_back(tick_row());
    plan.push_back(cfg_row(fcc_pkg::REG_RUNNING, 32'd1));
    plan.push_back(cfg_row(fcc_pkg::REG_RATE, 32'd0));
    plan.push_back(tick_row());
    plan.push_back(cfg_row(fcc_pkg::REG_RATE, 32'd4));
    plan.push_back(cfg_row(fcc_pkg::REG_ENABLE, 32'd0));
    plan.push_back(tick_row());
    plan.push_back(cfg_row(fcc_pkg::REG_ENABLE, 32'd1));
    plan.push_back(tick_row());

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        settle();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_word(plan[i].word, plan[i].pinned, plan[i].want);
      end
    end

    // Random phases: new settings each phase, then a run of mostly ticks
    // with loads steering the clock to calendar edges
    random_sent = 0;
    while (random_sent < RANDOM_WORDS) begin
      settle();
      calm = ($urandom_range(0, 3) == 0);
      write_reg(fcc_pkg::REG_RATE, fcc_pkg::PDATA_W'(random_rate()));
      write_reg(fcc_pkg::REG_RUNNING, fcc_pkg::PDATA_W'($urandom_range(0, 7) != 0));
      write_reg(fcc_pkg::REG_ENABLE, fcc_pkg::PDATA_W'($urandom_range(0, 7) != 0));
      len = $urandom_range(30, 90);
      repeat (len) begin
        if ($urandom_range(0, 7) == 0)
          send_word(random_load(), 1'b0, '0);
        else
          send_word(junk_tick(), 1'b0, '0);
        random_sent++;
      end
    end

    settle();
    // Give a stray extra result time to show up
    repeat (8) @(posedge clk);

    $display("Ran %0d words (%0d loads) over %0d register writes.", n_words, n_loads,
             n_settings);
    $display("Saw %0d minute steps, %0d day rolls, %0d month and %0d year changes.",
             n_steps, n_rolls, n_months, n_years);
    if (mismatches == 0)
      $display("fast_clock_calendar_tick_unit: match");
    else
      $display("fast_clock_calendar_tick_unit: mismatch");
    $finish;
  end

endmodule
